// File: sv/gda_pkg.sv
// Gregorian date arithmetic: shared types, step codes and calendar helpers.
// No dependencies; imported by every module of the block.
package gda_pkg;

	// field widths of the request and result
	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 14;
	localparam int OFF_W  = 22;

	localparam int unsigned MAX_YEAR_DEF   = 9999;
	localparam int unsigned MAX_OFFSET_DEF = 4194303;

	localparam logic [OFF_W-1:0] DIFF_MAX = 22'h3FFFFF;

	// opcodes
	localparam logic [1:0] OP_DIFF = 2'd0;
	localparam logic [1:0] OP_ADD  = 2'd1;
	localparam logic [1:0] OP_SUB  = 2'd2;

	// floor(y/100) = (y * RECIP_100) >> RECIP_SH, exact for y < 199728
	localparam int RECIP_W  = 18;
	localparam int RECIP_SH = 24;
	localparam logic [RECIP_W-1:0] RECIP_100 = 18'd167773;

	// datapath step codes
	localparam logic [3:0] DP_NOP    = 4'd0;
	localparam logic [3:0] DP_LOAD   = 4'd1;
	localparam logic [3:0] DP_MUL_A  = 4'd2;
	localparam logic [3:0] DP_ORD_A  = 4'd3;
	localparam logic [3:0] DP_MUL_B  = 4'd4;
	localparam logic [3:0] DP_ORD_B  = 4'd5;
	localparam logic [3:0] DP_DECIDE = 4'd6;
	localparam logic [3:0] DP_MUL_T  = 4'd7;
	localparam logic [3:0] DP_CMP_T  = 4'd8;
	localparam logic [3:0] DP_MUL_Y  = 4'd9;
	localparam logic [3:0] DP_SUB_Y  = 4'd10;
	localparam logic [3:0] DP_MONTH  = 4'd11;

	typedef struct packed {
		logic [3:0] step;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic search;   // add/sub result needs the year search
		logic bs_last;  // last bit of the year search
		logic mon_end;  // month walk has found the month
	} stat_t;

	// days from 1.1.0 to 1.1.y, elaboration use only
	function automatic int year_start_f(input int y);
		return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
	endfunction

	// days before month m in a common year
	function automatic logic [8:0] month_start_f(input logic [MON_W-1:0] m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [DAY_W-1:0] month_len_f(input logic [MON_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] r;
		case (m)
			4'd2:                      r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
			default:                   r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

// File: sv/gregorian_date_arithmetic_unit.sv
// Gregorian date arithmetic unit, top level: controller plus datapath.
// Uses gda_pkg, gda_ctrl, gda_dpath (which holds gda_year).
//
// One request at a time. Op 0 gives the absolute day count between A and B,
// op 1 adds offset_days to A, op 2 subtracts it; every result carries the
// A-before-B and A-equals-B flags, op 3 gives only those flags. Dates are
// proleptic Gregorian (year 0 is leap); out-of-range months, days and years
// are clamped first, and an add/sub result past 31.12.MAX_YEAR or before
// 1.1.0 saturates with out_of_range set. A non-saturated add/sub also runs
// a binary year search over W = clog2(MAX_YEAR+2) bits (14 bits at the
// default), one trial year per bit, and a month walk over up to 12 months.
// The shared year-start unit, with its one registered multiply, sets the
// pace. in_ready is high whenever the unit is idle, even while a finished
// result still waits in the output register; a new result is held back
// only until that one is taken.
module gregorian_date_arithmetic_unit #(
	parameter int unsigned MAX_YEAR   = gda_pkg::MAX_YEAR_DEF,
	parameter int unsigned MAX_OFFSET = gda_pkg::MAX_OFFSET_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  op,
	input  logic [gda_pkg::DAY_W-1:0]   day_a,
	input  logic [gda_pkg::MON_W-1:0]   month_a,
	input  logic [gda_pkg::YEAR_W-1:0]  year_a,
	input  logic [gda_pkg::DAY_W-1:0]   day_b,
	input  logic [gda_pkg::MON_W-1:0]   month_b,
	input  logic [gda_pkg::YEAR_W-1:0]  year_b,
	input  logic [gda_pkg::OFF_W-1:0]   offset_days,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [gda_pkg::DAY_W-1:0]   out_day,
	output logic [gda_pkg::MON_W-1:0]   out_month,
	output logic [gda_pkg::YEAR_W-1:0]  out_year,
	output logic [gda_pkg::OFF_W-1:0]   diff_days,
	output logic                        a_before_b,
	output logic                        dates_equal,
	output logic                        out_of_range
);
	import gda_pkg::*;

	// command and status between sequencer and datapath
	cmd_t  cmd;
	stat_t stat;

	gda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// request/result registers, ordinals, year search and month walk
	gda_dpath #(
		.MAX_YEAR   (MAX_YEAR),
		.MAX_OFFSET (MAX_OFFSET)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.op           (op),
		.day_a        (day_a),
		.month_a      (month_a),
		.year_a       (year_a),
		.day_b        (day_b),
		.month_b      (month_b),
		.year_b       (year_b),
		.offset_days  (offset_days),
		.out_day      (out_day),
		.out_month    (out_month),
		.out_year     (out_year),
		.diff_days    (diff_days),
		.a_before_b   (a_before_b),
		.dates_equal  (dates_equal),
		.out_of_range (out_of_range)
	);

endmodule

// File: sv/gda_year.sv
// Year-start unit: days from 1.1.0 to 1.1.y plus the leap flag of y.
// One registered multiply (reciprocal of 100), result used the next cycle. Uses gda_pkg.
module gda_year #(
	parameter int YR_W  = 14,
	parameter int ORD_W = 22
) (
	input  logic             clk,
	input  logic             load,
	input  logic [YR_W-1:0]  y_in,
	output logic [YR_W-1:0]  y,
	output logic [ORD_W-1:0] ys,
	output logic             leap
);
	import gda_pkg::*;

	localparam int PW  = YR_W + RECIP_W;
	localparam int D_W = YR_W - 5;

	logic [PW-1:0]   prod;
	logic [YR_W-1:0] y_q;
	logic [D_W-1:0]  d100_q;
	logic [YR_W-1:0] r_full;
	logic            nz;
	logic [D_W:0]    c100;
	logic [D_W:0]    c400;
	logic [YR_W:0]   y4;

	assign prod = PW'(y_in) * PW'(RECIP_100);

	always_ff @(posedge clk) begin
		if (load) begin
			y_q    <= y_in;
			d100_q <= D_W'(prod >> RECIP_SH);
		end
	end

	// remainder mod 100 and the rounded-up quotients
	assign r_full = y_q - YR_W'(d100_q) * YR_W'(100);
	assign nz     = (r_full != '0);
	assign c100   = (D_W+1)'(d100_q) + (D_W+1)'(nz);
	assign c400   = (c100 + (D_W+1)'(3)) >> 2;
	assign y4     = ((YR_W+1)'(y_q) + (YR_W+1)'(3)) >> 2;

	assign y    = y_q;
	assign ys   = ORD_W'(y_q) * ORD_W'(365) + ORD_W'(y4) - ORD_W'(c100) + ORD_W'(c400);
	assign leap = ((y_q[1:0] == 2'd0) && nz) || (!nz && (d100_q[1:0] == 2'd0));

endmodule

// File: sv/gda_dpath.sv
// Datapath: request registers, ordinals, decision, binary year search, month walk
// and the result register. Uses gda_pkg and gda_year; steered by gda_ctrl.
module gda_dpath #(
	parameter int unsigned MAX_YEAR   = gda_pkg::MAX_YEAR_DEF,
	parameter int unsigned MAX_OFFSET = gda_pkg::MAX_OFFSET_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gda_pkg::cmd_t               cmd,
	output gda_pkg::stat_t              stat,
	input  logic [1:0]                  op,
	input  logic [gda_pkg::DAY_W-1:0]   day_a,
	input  logic [gda_pkg::MON_W-1:0]   month_a,
	input  logic [gda_pkg::YEAR_W-1:0]  year_a,
	input  logic [gda_pkg::DAY_W-1:0]   day_b,
	input  logic [gda_pkg::MON_W-1:0]   month_b,
	input  logic [gda_pkg::YEAR_W-1:0]  year_b,
	input  logic [gda_pkg::OFF_W-1:0]   offset_days,
	output logic [gda_pkg::DAY_W-1:0]   out_day,
	output logic [gda_pkg::MON_W-1:0]   out_month,
	output logic [gda_pkg::YEAR_W-1:0]  out_year,
	output logic [gda_pkg::OFF_W-1:0]   diff_days,
	output logic                        a_before_b,
	output logic                        dates_equal,
	output logic                        out_of_range
);
	import gda_pkg::*;

	localparam int YR_W  = $clog2(MAX_YEAR + 2);
	localparam int ORD_W = $clog2(year_start_f(2 ** YR_W) + 1);
	localparam int CW    = (ORD_W > OFF_W) ? ORD_W : OFF_W;
	localparam int BW    = $clog2(YR_W);
	localparam int LAST_I = year_start_f(MAX_YEAR + 1) - 1;
	localparam logic [ORD_W-1:0] LAST = ORD_W'(LAST_I);

	// request, normalized except for the day
	logic [1:0]       op_q;
	logic [DAY_W-1:0] da_q, db_q;
	logic [MON_W-1:0] ma_q, mb_q;
	logic [YR_W-1:0]  ya_q, yb_q;
	logic [OFF_W-1:0] off_q;

	logic [ORD_W-1:0] oa_q, ob_q, n_q;
	logic [YR_W-1:0]  yr_q;
	logic [BW-1:0]    bit_q;
	logic [8:0]       rem_q;
	logic [MON_W-1:0] mo_q;
	logic             leap_q;

	// working result
	logic [DAY_W-1:0]  rd_q;
	logic [MON_W-1:0]  rm_q;
	logic [YEAR_W-1:0] ry_q;
	logic [OFF_W-1:0]  diff_q;
	logic              lt_q, eq_q, oor_q;

	// year unit
	logic             yu_load;
	logic [YR_W-1:0]  yu_in, yu_y;
	logic [ORD_W-1:0] yu_ys;
	logic             yu_leap;

	gda_year #(.YR_W(YR_W), .ORD_W(ORD_W)) u_year (
		.clk  (clk),
		.load (yu_load),
		.y_in (yu_in),
		.y    (yu_y),
		.ys   (yu_ys),
		.leap (yu_leap)
	);

	logic [YR_W-1:0] t_try;
	assign t_try = yr_q | (YR_W'(1) << bit_q);

	always_comb begin
		yu_load = 1'b1;
		case (cmd.step)
			DP_MUL_A: yu_in = ya_q;
			DP_MUL_B: yu_in = yb_q;
			DP_MUL_T: yu_in = t_try;
			DP_MUL_Y: yu_in = yr_q;
			default: begin
				yu_in   = yr_q;
				yu_load = 1'b0;
			end
		endcase
	end

	// input normalization
	function automatic logic [MON_W-1:0] clamp_mon(input logic [MON_W-1:0] m);
		logic [MON_W-1:0] r;
		r = m;
		if (m == 4'd0) r = 4'd1;
		if (m > 4'd12) r = 4'd12;
		return r;
	endfunction

	function automatic logic [YR_W-1:0] clamp_year(input logic [YEAR_W-1:0] y);
		return (32'(y) > MAX_YEAR) ? YR_W'(MAX_YEAR) : YR_W'(y);
	endfunction

	// ordinal of the date whose year sits in the year unit
	logic [DAY_W-1:0] o_day, o_len, o_dd;
	logic [MON_W-1:0] o_mon;
	logic [ORD_W-1:0] o_ord;

	always_comb begin
		o_day = (cmd.step == DP_ORD_B) ? db_q : da_q;
		o_mon = (cmd.step == DP_ORD_B) ? mb_q : ma_q;
		o_len = month_len_f(o_mon, yu_leap);
		o_dd  = (o_day == '0) ? DAY_W'(1) : o_day;
		if (o_dd > o_len)
			o_dd = o_len;
		o_ord = yu_ys + ORD_W'(month_start_f(o_mon))
			+ ORD_W'(yu_leap && (o_mon > 4'd2)) + ORD_W'(o_dd) - ORD_W'(1);
	end

	// decision
	logic             sat_add, sat_sub;
	logic [ORD_W-1:0] span;

	assign sat_add = CW'(off_q) > CW'(LAST - oa_q);
	assign sat_sub = CW'(off_q) > CW'(oa_q);
	assign span    = (oa_q > ob_q) ? (oa_q - ob_q) : (ob_q - oa_q);

	logic [DAY_W-1:0] m_len;
	assign m_len = month_len_f(mo_q, leap_q);

	assign stat.search  = ((op_q == OP_ADD) && !sat_add) || ((op_q == OP_SUB) && !sat_sub);
	assign stat.bs_last = (bit_q == '0);
	assign stat.mon_end = (rem_q < 9'(m_len));

	always_ff @(posedge clk) begin
		case (cmd.step)
			DP_LOAD: begin
				op_q  <= op;
				da_q  <= day_a;
				db_q  <= day_b;
				ma_q  <= clamp_mon(month_a);
				mb_q  <= clamp_mon(month_b);
				ya_q  <= clamp_year(year_a);
				yb_q  <= clamp_year(year_b);
				off_q <= (32'(offset_days) > MAX_OFFSET) ? OFF_W'(MAX_OFFSET) : offset_days;
			end
			DP_ORD_A: oa_q <= o_ord;
			DP_ORD_B: ob_q <= o_ord;
			DP_DECIDE: begin
				lt_q   <= (oa_q < ob_q);
				eq_q   <= (oa_q == ob_q);
				yr_q   <= '0;
				bit_q  <= BW'(YR_W - 1);
				rd_q   <= '0;
				rm_q   <= '0;
				ry_q   <= '0;
				diff_q <= '0;
				oor_q  <= 1'b0;
				case (op_q)
					OP_DIFF: diff_q <= (CW'(span) > CW'(DIFF_MAX)) ? DIFF_MAX : OFF_W'(span);
					OP_ADD: begin
						n_q <= ORD_W'(CW'(oa_q) + CW'(off_q));
						if (sat_add) begin
							rd_q  <= 5'd31;
							rm_q  <= 4'd12;
							ry_q  <= YEAR_W'(MAX_YEAR);
							oor_q <= 1'b1;
						end
					end
					OP_SUB: begin
						n_q <= ORD_W'(CW'(oa_q) - CW'(off_q));
						if (sat_sub) begin
							rd_q  <= 5'd1;
							rm_q  <= 4'd1;
							oor_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			DP_CMP_T: begin
				// keep the trial bit when that year starts on or before n
				if (yu_ys <= n_q)
					yr_q <= yu_y;
				bit_q <= bit_q - BW'(1);
			end
			DP_SUB_Y: begin
				rem_q  <= 9'(n_q - yu_ys);
				leap_q <= yu_leap;
				mo_q   <= 4'd1;
				ry_q   <= YEAR_W'(yr_q);
			end
			DP_MONTH: begin
				if (rem_q >= 9'(m_len)) begin
					rem_q <= rem_q - 9'(m_len);
					mo_q  <= mo_q + 4'd1;
				end else begin
					rd_q <= DAY_W'(rem_q) + DAY_W'(1);
					rm_q <= mo_q;
				end
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_day      <= rd_q;
			out_month    <= rm_q;
			out_year     <= ry_q;
			diff_days    <= diff_q;
			a_before_b   <= lt_q;
			dates_equal  <= eq_q;
			out_of_range <= oor_q;
		end
	end

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step == DP_MONTH) |-> (mo_q >= 4'd1 && mo_q <= 4'd12))
		else $error("month walk left 1..12");

	a_rem_in_year: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step == DP_SUB_Y) |=> (rem_q < 9'd366))
		else $error("day of year out of range after year search");

endmodule

// File: sv/gda_ctrl.sv
// Controller: sequences one request through the datapath and owns the output valid.
// Uses gda_pkg for the step codes and the command/status structs.
module gda_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output gda_pkg::cmd_t  cmd,
	input  gda_pkg::stat_t stat
);
	import gda_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MUL_A  = 4'd1;
	localparam logic [3:0] S_ORD_A  = 4'd2;
	localparam logic [3:0] S_MUL_B  = 4'd3;
	localparam logic [3:0] S_ORD_B  = 4'd4;
	localparam logic [3:0] S_DECIDE = 4'd5;
	localparam logic [3:0] S_MUL_T  = 4'd6;
	localparam logic [3:0] S_CMP_T  = 4'd7;
	localparam logic [3:0] S_MUL_Y  = 4'd8;
	localparam logic [3:0] S_SUB_Y  = 4'd9;
	localparam logic [3:0] S_MONTH  = 4'd10;
	localparam logic [3:0] S_FIN    = 4'd11;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d      = state_q;
		cmd.step     = DP_NOP;
		cmd.load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.step = DP_LOAD;
					state_d  = S_MUL_A;
				end
			end
			S_MUL_A: begin
				cmd.step = DP_MUL_A;
				state_d  = S_ORD_A;
			end
			S_ORD_A: begin
				cmd.step = DP_ORD_A;
				state_d  = S_MUL_B;
			end
			S_MUL_B: begin
				cmd.step = DP_MUL_B;
				state_d  = S_ORD_B;
			end
			S_ORD_B: begin
				cmd.step = DP_ORD_B;
				state_d  = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.step = DP_DECIDE;
				state_d  = stat.search ? S_MUL_T : S_FIN;
			end
			S_MUL_T: begin
				cmd.step = DP_MUL_T;
				state_d  = S_CMP_T;
			end
			S_CMP_T: begin
				cmd.step = DP_CMP_T;
				state_d  = stat.bs_last ? S_MUL_Y : S_MUL_T;
			end
			S_MUL_Y: begin
				cmd.step = DP_MUL_Y;
				state_d  = S_SUB_Y;
			end
			S_SUB_Y: begin
				cmd.step = DP_SUB_Y;
				state_d  = S_MONTH;
			end
			S_MONTH: begin
				cmd.step = DP_MONTH;
				if (stat.mon_end)
					state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_MUL_A))
		else $error("accepted request did not start the sequence");

	a_fin_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_valid && !out_ready) |=> (state_q == S_FIN && out_valid))
		else $error("result overwrote an untaken result");

	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == S_FIN))
		else $error("result valid raised outside the finish state");

endmodule
